>>> sv/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// shared types and constants for the rtp header parser
// ----------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

  // rtp version carried in the top two bits of byte 0
  localparam logic [1:0] RTP_VERSION = 2'd2;

  // fixed header layout
  localparam int FIXED_HDR_BYTES = 12;
  localparam int HDR_LAST_BYTE   = FIXED_HDR_BYTES - 1;
  localparam int HDR_STORE_BYTES = 8;

  // byte position only matters up to the end of the extension header
  // (12 + 15*4 + 4 = 76), so it saturates at 127
  localparam int POS_W = 7;

  // extension data length in bytes: 16-bit word count times four
  localparam int EXT_LEFT_W = 18;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_CSRC = 3'd1,
    PH_EXTH = 3'd2,
    PH_EXTD = 3'd3,
    PH_PAY  = 3'd4,
    PH_DISC = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CLS_HDR  = 3'd0,
    CLS_CSRC = 3'd1,
    CLS_EXTH = 3'd2,
    CLS_EXTD = 3'd3,
    CLS_PAY  = 3'd4,
    CLS_DISC = 3'd5
  } byte_class_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_VER = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_end;
  } rhp_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    byte_class_t byte_class;
    logic        packet_done;
    logic        header_valid;
    logic        marker_bit;
    logic [6:0]  payload_kind;
    logic [15:0] seq_number;
    logic [31:0] media_time;
    logic [15:0] ext_profile_id;
    logic [15:0] ext_word_count;
    status_t     parse_status;
  } rhp_result_t;

endpackage

`default_nettype wire

>>> sv/rtp_header_parser.sv
// ----------------------------------------------------------------------------
// rtp_header_parser
// rtp fixed header parser, one packet byte per transaction
// ----------------------------------------------------------------------------
// usage:
//   in_*  channel carries one packet byte per transaction, in_packet_end high
//         on the final byte of a packet
//   out_* channel returns one result per input byte: the byte echoed, its
//         class (header, csrc, ext header, ext data, payload, discarded) and
//         the header fields assembled so far, plus parse status
//   path: the accepted byte passes the input register, then the result
//         register, before out_valid rises
//   throughput: one byte per cycle while out_ready is high; the parse step is
//               one pass of logic between the input register and result register
//   stall: when out_ready is low the result register holds, the input
//          register fills, and in_ready drops until the result is taken
//   reset: synchronous active-low rst_n empties both registers and returns
//          the parse state to the start of a packet
//   a packet with a version other than 2 is marked discarded with bad
//   version status; one ending before its header or extension is complete
//   reports truncated on its last byte
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_header_parser
  import rhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_packet_end,

  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_data_byte,
  output logic [2:0]       out_byte_class,
  output logic             out_packet_done,
  output logic             out_header_valid,
  output logic             out_marker_bit,
  output logic [6:0]       out_payload_kind,
  output logic [15:0]      out_seq_number,
  output logic [31:0]      out_media_time,
  output logic [15:0]      out_ext_profile_id,
  output logic [15:0]      out_ext_word_count,
  output logic [1:0]       out_parse_status
);

  rhp_item_t   in_item;
  rhp_item_t   item;
  logic        item_valid;
  logic        item_ready;
  rhp_result_t result;

  assign in_item.rx_byte    = in_rx_byte;
  assign in_item.packet_end = in_packet_end;

  // input register: decouples the input handshake from the parse step
  rhp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // parse step and result register
  rhp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .result     (result)
  );

  // unpack the result transaction onto the ports
  assign out_data_byte      = result.data_byte;
  assign out_byte_class     = result.byte_class;
  assign out_packet_done    = result.packet_done;
  assign out_header_valid   = result.header_valid;
  assign out_marker_bit     = result.marker_bit;
  assign out_payload_kind   = result.payload_kind;
  assign out_seq_number     = result.seq_number;
  assign out_media_time     = result.media_time;
  assign out_ext_profile_id = result.ext_profile_id;
  assign out_ext_word_count = result.ext_word_count;
  assign out_parse_status   = result.parse_status;

endmodule

`default_nettype wire

>>> sv/rhp_in_reg.sv
// ----------------------------------------------------------------------------
// rhp_in_reg
// input register stage with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_in_reg
  import rhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rhp_item_t in_item,
  output logic           item_valid,
  input  wire logic      item_ready,
  output rhp_item_t      item
);

  logic      vld_r;
  logic      vld_nxt;
  rhp_item_t item_r;

  // take a new transaction when empty or when the held one moves on
  assign in_ready = !vld_r || item_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> sv/rhp_parser.sv
// ----------------------------------------------------------------------------
// rhp_parser
// per-packet parse state, byte classification and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_parser
  import rhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire rhp_item_t item,
  output logic           res_valid,
  input  wire logic      res_ready,
  output rhp_result_t    result
);

  phase_t                phase_r, phase_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [3:0]            cc_r, cc_nxt;
  logic                  x_r, x_nxt;
  logic [EXT_LEFT_W-1:0] ext_left_r, ext_left_nxt;
  logic [63:0]           hdr_r, hdr_nxt;
  logic [31:0]           ext_r, ext_nxt;
  status_t               err_r, err_nxt;

  logic                  res_vld_r;
  rhp_result_t           res_r;
  rhp_result_t           res_nxt;

  logic                  fire;
  logic [POS_W-1:0]      csrc_end;
  logic [POS_W:0]        pos_inc;
  phase_t                after_csrc;
  logic [1:0]            ext_off;
  logic [EXT_LEFT_W-1:0] ext_left_dec;
  byte_class_t           cls;
  logic                  hdr_ok;

  assign item_ready = !res_vld_r || res_ready;
  assign fire       = item_valid && item_ready;

  assign csrc_end   = POS_W'(FIXED_HDR_BYTES) + POS_W'({cc_r, 2'b00});
  assign pos_inc    = {1'b0, pos_r} + (POS_W+1)'(1);
  assign after_csrc = x_r ? PH_EXTH : PH_PAY;
  // csrc_end is a multiple of four, so the offset in the extension header
  // is just the low bits of the position
  assign ext_off    = pos_r[1:0];
  assign ext_left_dec = (ext_left_r != '0) ? ext_left_r - EXT_LEFT_W'(1) : ext_left_r;

  always_comb begin
    phase_nxt    = phase_r;
    cc_nxt       = cc_r;
    x_nxt        = x_r;
    ext_left_nxt = ext_left_r;
    hdr_nxt      = hdr_r;
    ext_nxt      = ext_r;
    err_nxt      = err_r;
    cls          = CLS_DISC;

    case (phase_r)
      PH_HDR: begin
        cls = CLS_HDR;
        if (pos_r == '0 && item.rx_byte[7:6] != RTP_VERSION) begin
          err_nxt   = ST_BAD_VER;
          phase_nxt = PH_DISC;
          cls       = CLS_DISC;
        end else begin
          if (pos_r == '0) begin
            cc_nxt = item.rx_byte[3:0];
            x_nxt  = item.rx_byte[4];
          end
          if (pos_r < POS_W'(HDR_STORE_BYTES)) begin
            hdr_nxt[{~pos_r[2:0], 3'b000} +: 8] =
              hdr_r[{~pos_r[2:0], 3'b000} +: 8] | item.rx_byte;
          end
          if (pos_r >= POS_W'(HDR_LAST_BYTE)) begin
            phase_nxt = (cc_r != '0) ? PH_CSRC : after_csrc;
          end
        end
      end
      PH_CSRC: begin
        cls = CLS_CSRC;
        if (pos_inc >= {1'b0, csrc_end}) begin
          phase_nxt = after_csrc;
        end
      end
      PH_EXTH: begin
        cls = CLS_EXTH;
        ext_nxt[{~ext_off, 3'b000} +: 8] = ext_r[{~ext_off, 3'b000} +: 8] | item.rx_byte;
        if (ext_off == 2'd3) begin
          ext_left_nxt = {ext_nxt[15:0], 2'b00};
          phase_nxt    = (ext_nxt[15:0] != '0) ? PH_EXTD : PH_PAY;
        end
      end
      PH_EXTD: begin
        cls          = CLS_EXTD;
        ext_left_nxt = ext_left_dec;
        if (ext_left_dec == '0) begin
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY: begin
        cls = CLS_PAY;
      end
      default: begin
        cls       = CLS_DISC;
        phase_nxt = PH_DISC;
      end
    endcase

    pos_nxt = (pos_r != '1) ? pos_inc[POS_W-1:0] : pos_r;

    // packet ended before reaching payload
    if (item.packet_end && err_nxt == ST_OK && phase_nxt != PH_PAY) begin
      err_nxt = ST_TRUNC;
    end

    hdr_ok = err_nxt != ST_BAD_VER && phase_nxt != PH_HDR && phase_nxt != PH_DISC;

    res_nxt.data_byte      = item.rx_byte;
    res_nxt.byte_class     = cls;
    res_nxt.packet_done    = item.packet_end;
    res_nxt.header_valid   = hdr_ok;
    res_nxt.marker_bit     = hdr_nxt[55];
    res_nxt.payload_kind   = hdr_nxt[54:48];
    res_nxt.seq_number     = hdr_nxt[47:32];
    res_nxt.media_time     = hdr_nxt[31:0];
    res_nxt.ext_profile_id = ext_nxt[31:16];
    res_nxt.ext_word_count = ext_nxt[15:0];
    res_nxt.parse_status   = err_nxt;
  end

  // parse state, cleared at reset and after the last byte of a packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR;
      pos_r      <= '0;
      cc_r       <= '0;
      x_r        <= 1'b0;
      ext_left_r <= '0;
      hdr_r      <= '0;
      ext_r      <= '0;
      err_r      <= ST_OK;
    end else if (fire) begin
      if (item.packet_end) begin
        phase_r    <= PH_HDR;
        pos_r      <= '0;
        cc_r       <= '0;
        x_r        <= 1'b0;
        ext_left_r <= '0;
        hdr_r      <= '0;
        ext_r      <= '0;
        err_r      <= ST_OK;
      end else begin
        phase_r    <= phase_nxt;
        pos_r      <= pos_nxt;
        cc_r       <= cc_nxt;
        x_r        <= x_nxt;
        ext_left_r <= ext_left_nxt;
        hdr_r      <= hdr_nxt;
        ext_r      <= ext_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (fire) begin
      res_vld_r <= 1'b1;
    end else if (res_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_vld_r;
  assign result    = res_r;

endmodule

`default_nettype wire

>>> sv/rhp_checker.sv
// ----------------------------------------------------------------------------
// rhp_checker
// port-level checks for the rtp header parser
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_checker
  import rhp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_data_byte,
  input wire logic [2:0]  out_byte_class,
  input wire logic        out_packet_done,
  input wire logic        out_header_valid,
  input wire logic [1:0]  out_parse_status
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte))
    else $error("result changed while stalled");

  // a bad-version packet is discarded and never shows a valid header
  a_bad_ver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status == ST_BAD_VER |->
      out_byte_class == CLS_DISC && !out_header_valid)
    else $error("bad version byte not discarded");

  // truncation is only reported on the last byte
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status == ST_TRUNC |-> out_packet_done)
    else $error("truncated status before packet end");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_data_byte    (out_data_byte),
  .out_byte_class   (out_byte_class),
  .out_packet_done  (out_packet_done),
  .out_header_valid (out_header_valid),
  .out_parse_status (out_parse_status)
);

`default_nettype wire
